// ----- hw/rtl/dtf_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// dtf_pkg
// Shared types and constants of the depth tested fragment unit.
// ----------------------------------------------------------------------------
package dtf_pkg;

	localparam int SCREEN_WIDTH_DEF  = 1024;
	localparam int SCREEN_HEIGHT_DEF = 1024;

	localparam int PIX_W    = 10;
	localparam int COORD_W  = 13;
	localparam int DIFF_W   = 14;
	localparam int PROD_W   = 28;
	localparam int AREA_W   = 29;
	localparam int NC_W     = 31;
	localparam int W_W      = 32;
	localparam int COLOR_W  = 32;
	localparam int DEPTH_W  = 32;
	localparam int RECIP_W  = 33;
	localparam int CHUNK_W  = 16;
	localparam int MPROD_W  = 48;
	localparam int ACC_W    = 64;
	localparam int DIVD_W   = 64;
	localparam int DIVS_W   = 32;
	localparam int CLAMP_W  = 41;

	localparam logic signed [DEPTH_W-1:0] ONE_Q16 = 32'sh0001_0000;
	localparam logic [DIVD_W-1:0] RECIP_NUM = 64'h0000_0001_0000_0000;
	localparam logic [CLAMP_W-1:0] Q_CLAMP = 41'h100_0000_0000;

	localparam logic [1:0] TERM_A = 2'd0;
	localparam logic [1:0] TERM_B = 2'd1;
	localparam logic [1:0] TERM_C = 2'd2;
	localparam logic [1:0] CHUNK_LO  = 2'd0;
	localparam logic [1:0] CHUNK_MID = 2'd1;
	localparam logic [1:0] CHUNK_HI  = 2'd2;

	typedef struct packed {
		logic                     compute;
		logic                     onscreen;
		logic signed [AREA_W-1:0] area;
		logic signed [AREA_W-1:0] na;
		logic signed [AREA_W-1:0] nb;
		logic signed [NC_W-1:0]   nc;
		logic [W_W-1:0]           wa;
		logic [W_W-1:0]           wb;
		logic [W_W-1:0]           wc;
		logic [COLOR_W-1:0]       color;
		logic [PIX_W-1:0]         px;
		logic [PIX_W-1:0]         py;
	} frag_t;

	typedef struct packed {
		logic              start;
		logic [DIVD_W-1:0] dividend;
		logic [DIVS_W-1:0] divisor;
	} div_req_t;

	typedef enum logic [3:0] {
		BK_CLEAR,
		BK_IDLE,
		BK_RSTART,
		BK_RECIP,
		BK_MUL,
		BK_ACC,
		BK_DSTART,
		BK_DIV,
		BK_RD,
		BK_CMP,
		BK_OUT
	} back_state_t;

endpackage
`default_nettype wire

// ----- hw/rtl/dtf_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// dtf_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module dtf_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

// ----- hw/rtl/dtf_div.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// dtf_div
// Shared restoring divider, one quotient bit per cycle, unsigned.
// ----------------------------------------------------------------------------
module dtf_div (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire dtf_pkg::div_req_t         req,
	output logic                           done,
	output logic [dtf_pkg::DIVD_W-1:0]     quo
);

	logic                          run_q;
	logic                          done_q;
	logic [5:0]                    cnt_q;
	logic [dtf_pkg::DIVS_W-1:0]    rem_q;
	logic [dtf_pkg::DIVS_W-1:0]    dvs_q;
	logic [dtf_pkg::DIVD_W-1:0]    quo_q;
	logic [dtf_pkg::DIVS_W:0]      rem_sh;
	logic [dtf_pkg::DIVS_W:0]      rem_sub;
	logic                          ge;

	always_comb begin
		rem_sh  = {rem_q, quo_q[dtf_pkg::DIVD_W-1]};
		ge      = rem_sh >= {1'b0, dvs_q};
		rem_sub = ge ? (rem_sh - {1'b0, dvs_q}) : rem_sh;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= run_q && (&cnt_q);
			if (req.start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (&cnt_q) begin
					run_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			dvs_q <= req.divisor;
			quo_q <= req.dividend;
		end else if (run_q) begin
			rem_q <= rem_sub[dtf_pkg::DIVS_W-1:0];
			quo_q <= {quo_q[dtf_pkg::DIVD_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule
`default_nettype wire

// ----- hw/rtl/dtf_queue.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// dtf_queue
// Two-entry fragment queue between the front and the back.
// ----------------------------------------------------------------------------
module dtf_queue (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  wire dtf_pkg::frag_t  wdata,
	output logic                 full,
	input  wire logic            pop,
	output dtf_pkg::frag_t       rdata,
	output logic                 empty
);

	dtf_pkg::frag_t ent_q [2];
	logic           wptr_q;
	logic           rptr_q;
	logic [1:0]     cnt_q;

	assign full  = cnt_q == 2'd2;
	assign empty = cnt_q == 2'd0;
	assign rdata = ent_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			if (push) begin
				wptr_q <= ~wptr_q;
			end
			if (pop) begin
				rptr_q <= ~rptr_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wptr_q] <= wdata;
		end
	end

endmodule
`default_nettype wire

// ----- hw/rtl/dtf_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// dtf_front
// Accepts fragments, forms the edge areas and classifies each fragment.
// ----------------------------------------------------------------------------
module dtf_front #(
	parameter int SCREEN_WIDTH  = dtf_pkg::SCREEN_WIDTH_DEF,
	parameter int SCREEN_HEIGHT = dtf_pkg::SCREEN_HEIGHT_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   hold,
	input  wire logic                   push,
	output logic                        full,
	input  wire logic [9:0]             pixel_x,
	input  wire logic [9:0]             pixel_y,
	input  wire logic signed [12:0]     vert_a_x,
	input  wire logic signed [12:0]     vert_a_y,
	input  wire logic [31:0]            vert_a_w,
	input  wire logic signed [12:0]     vert_b_x,
	input  wire logic signed [12:0]     vert_b_y,
	input  wire logic [31:0]            vert_b_w,
	input  wire logic signed [12:0]     vert_c_x,
	input  wire logic signed [12:0]     vert_c_y,
	input  wire logic [31:0]            vert_c_w,
	input  wire logic [31:0]            fill_color,
	input  wire logic                   q_full,
	output logic                        q_push,
	output dtf_pkg::frag_t              q_data
);

	localparam int DW = dtf_pkg::DIFF_W;
	localparam int PW = dtf_pkg::PROD_W;
	localparam int AW = dtf_pkg::AREA_W;
	localparam int NW = dtf_pkg::NC_W;

	logic advance;
	logic accept;

	logic signed [DW-1:0] ax, ay, bx, by, cx, cy, px, py;
	logic signed [PW-1:0] prod [6];

	logic                 valid_s1;
	logic signed [PW-1:0] prod_s1 [6];
	logic [31:0]          wa_s1, wb_s1, wc_s1, color_s1;
	logic [9:0]           px_s1, py_s1;

	logic                 valid_s2;
	dtf_pkg::frag_t       frag_s2;
	dtf_pkg::frag_t       frag_d;

	assign advance = !valid_s2 || !q_full;
	assign full    = hold || !advance;
	assign accept  = push && !full;
	assign q_push  = valid_s2 && !q_full;
	assign q_data  = frag_s2;

	always_comb begin
		ax = $signed({vert_a_x[12], vert_a_x});
		ay = $signed({vert_a_y[12], vert_a_y});
		bx = $signed({vert_b_x[12], vert_b_x});
		by = $signed({vert_b_y[12], vert_b_y});
		cx = $signed({vert_c_x[12], vert_c_x});
		cy = $signed({vert_c_y[12], vert_c_y});
		px = $signed({4'b0, pixel_x});
		py = $signed({4'b0, pixel_y});
		// area and the edge weights na and nb, each from a pair of products
		prod[0] = (bx - ax) * (cy - ay);
		prod[1] = (by - ay) * (cx - ax);
		prod[2] = (cx - bx) * (py - by);
		prod[3] = (px - bx) * (cy - by);
		prod[4] = (px - ax) * (cy - ay);
		prod[5] = (cx - ax) * (py - ay);
	end

	always_comb begin
		frag_d.area = $signed({prod_s1[0][PW-1], prod_s1[0]})
			- $signed({prod_s1[1][PW-1], prod_s1[1]});
		frag_d.na = $signed({prod_s1[2][PW-1], prod_s1[2]})
			- $signed({prod_s1[3][PW-1], prod_s1[3]});
		frag_d.nb = $signed({prod_s1[4][PW-1], prod_s1[4]})
			- $signed({prod_s1[5][PW-1], prod_s1[5]});
		frag_d.nc = $signed({{(NW-AW){frag_d.area[AW-1]}}, frag_d.area})
			- $signed({{(NW-AW){frag_d.na[AW-1]}}, frag_d.na})
			- $signed({{(NW-AW){frag_d.nb[AW-1]}}, frag_d.nb});
		frag_d.compute = (frag_d.area != '0) && (wa_s1 != '0) && (wb_s1 != '0)
			&& (wc_s1 != '0);
		frag_d.onscreen = (32'(px_s1) < 32'(SCREEN_WIDTH))
			&& (32'(py_s1) < 32'(SCREEN_HEIGHT));
		frag_d.wa    = wa_s1;
		frag_d.wb    = wb_s1;
		frag_d.wc    = wc_s1;
		frag_d.color = color_s1;
		frag_d.px    = px_s1;
		frag_d.py    = py_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			prod_s1  <= prod;
			wa_s1    <= vert_a_w;
			wb_s1    <= vert_b_w;
			wc_s1    <= vert_c_w;
			color_s1 <= fill_color;
			px_s1    <= pixel_x;
			py_s1    <= pixel_y;
			frag_s2  <= frag_d;
		end
	end

endmodule
`default_nettype wire

// ----- hw/rtl/dtf_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// dtf_back
// Sequencer for reciprocals, weighted sum, final divide and z-buffer update.
// ----------------------------------------------------------------------------
module dtf_back #(
	parameter int SCREEN_WIDTH  = dtf_pkg::SCREEN_WIDTH_DEF,
	parameter int SCREEN_HEIGHT = dtf_pkg::SCREEN_HEIGHT_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 q_empty,
	output logic                      q_pop,
	input  wire dtf_pkg::frag_t       q_data,
	output logic                      clearing,
	input  wire logic                 pop,
	output logic                      empty,
	output logic                      write_pixel,
	output logic [9:0]                out_x,
	output logic [9:0]                out_y,
	output logic [31:0]               out_color,
	output logic signed [31:0]        new_depth
);

	localparam int DEPTH  = SCREEN_WIDTH * SCREEN_HEIGHT;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam logic [ADDR_W-1:0] CLR_LAST = ADDR_W'(DEPTH - 1);
	localparam int AW = dtf_pkg::AREA_W;
	localparam int NW = dtf_pkg::NC_W;

	dtf_pkg::back_state_t state_q, state_d;
	dtf_pkg::frag_t       ent_q;
	logic [1:0]           term_q;
	logic [1:0]           chunk_q;
	logic [dtf_pkg::RECIP_W-1:0] recip_q;
	logic signed [dtf_pkg::MPROD_W-1:0] prod_q;
	logic signed [dtf_pkg::ACC_W-1:0]   acc_q;
	logic signed [31:0]   depth_q;
	logic [ADDR_W-1:0]    clr_q;
	logic                 out_valid_q;
	logic                 out_write_q;
	logic [9:0]           out_x_q, out_y_q;
	logic [31:0]          out_color_q;
	logic signed [31:0]   out_depth_q;

	logic [31:0]                        cur_w;
	logic signed [NW-1:0]               cur_n;
	logic [dtf_pkg::CHUNK_W-1:0]        chunk;
	logic signed [dtf_pkg::MPROD_W-1:0] prod;
	logic signed [dtf_pkg::ACC_W-1:0]   prod_ext;
	logic signed [dtf_pkg::ACC_W-1:0]   acc_sum;
	logic [dtf_pkg::ACC_W-1:0]          acc_mag;
	logic signed [31:0]                 area_ext;
	logic [31:0]                        area_mag;
	logic                               q_neg;
	logic [dtf_pkg::CLAMP_W-1:0]        q_mag;
	logic signed [dtf_pkg::CLAMP_W:0]   q_sgn;
	logic signed [dtf_pkg::CLAMP_W+1:0] d_wide;
	logic signed [31:0]                 depth_sat;
	logic                               depth_lt;
	logic [ADDR_W-1:0]                  addr;
	logic                               out_load;

	dtf_pkg::div_req_t           div_req;
	logic                        div_done;
	logic [dtf_pkg::DIVD_W-1:0]  div_quo;

	logic                 ram_we, ram_re;
	logic [ADDR_W-1:0]    ram_waddr;
	logic [31:0]          ram_wdata, ram_rdata;

	// ---- datapath helpers
	always_comb begin
		case (term_q)
			dtf_pkg::TERM_A: begin
				cur_w = ent_q.wa;
				cur_n = $signed({{(NW-AW){ent_q.na[AW-1]}}, ent_q.na});
			end
			dtf_pkg::TERM_B: begin
				cur_w = ent_q.wb;
				cur_n = $signed({{(NW-AW){ent_q.nb[AW-1]}}, ent_q.nb});
			end
			default: begin
				cur_w = ent_q.wc;
				cur_n = ent_q.nc;
			end
		endcase
		case (chunk_q)
			dtf_pkg::CHUNK_LO:  chunk = recip_q[15:0];
			dtf_pkg::CHUNK_MID: chunk = recip_q[31:16];
			default:            chunk = {15'b0, recip_q[32]};
		endcase
		prod     = $signed({1'b0, chunk}) * cur_n;
		prod_ext = $signed({{(dtf_pkg::ACC_W-dtf_pkg::MPROD_W){prod_q[dtf_pkg::MPROD_W-1]}},
			prod_q});
		case (chunk_q)
			dtf_pkg::CHUNK_LO:  acc_sum = acc_q + prod_ext;
			dtf_pkg::CHUNK_MID: acc_sum = acc_q + (prod_ext <<< 16);
			default:            acc_sum = acc_q + (prod_ext <<< 32);
		endcase
		acc_mag  = acc_q[dtf_pkg::ACC_W-1] ? (64'd0 - acc_q) : acc_q;
		area_ext = $signed({{(32-AW){ent_q.area[AW-1]}}, ent_q.area});
		area_mag = area_ext[31] ? (32'd0 - area_ext) : area_ext;
		// quotient sign, clamp to +-2^40, then one minus it, saturated
		q_neg  = acc_q[dtf_pkg::ACC_W-1] ^ ent_q.area[AW-1];
		q_mag  = (div_quo > 64'(dtf_pkg::Q_CLAMP)) ? dtf_pkg::Q_CLAMP
			: div_quo[dtf_pkg::CLAMP_W-1:0];
		q_sgn  = q_neg ? -$signed({1'b0, q_mag}) : $signed({1'b0, q_mag});
		d_wide = $signed(43'sd65536) - $signed({q_sgn[dtf_pkg::CLAMP_W], q_sgn});
		if (d_wide[dtf_pkg::CLAMP_W+1:31] == '0 || (&d_wide[dtf_pkg::CLAMP_W+1:31])) begin
			depth_sat = d_wide[31:0];
		end else if (d_wide[dtf_pkg::CLAMP_W+1]) begin
			depth_sat = 32'sh8000_0000;
		end else begin
			depth_sat = 32'sh7fff_ffff;
		end
		depth_lt = depth_q < $signed(ram_rdata);
		addr = ADDR_W'(32'(ent_q.py) * 32'(SCREEN_WIDTH) + 32'(ent_q.px));
	end

	// ---- next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			dtf_pkg::BK_CLEAR:  if (clr_q == CLR_LAST) state_d = dtf_pkg::BK_IDLE;
			dtf_pkg::BK_IDLE: begin
				if (!q_empty) begin
					state_d = q_data.compute ? dtf_pkg::BK_RSTART : dtf_pkg::BK_OUT;
				end
			end
			dtf_pkg::BK_RSTART: state_d = dtf_pkg::BK_RECIP;
			dtf_pkg::BK_RECIP:  if (div_done) state_d = dtf_pkg::BK_MUL;
			dtf_pkg::BK_MUL:    state_d = dtf_pkg::BK_ACC;
			dtf_pkg::BK_ACC: begin
				if (chunk_q != dtf_pkg::CHUNK_HI) begin
					state_d = dtf_pkg::BK_MUL;
				end else if (term_q == dtf_pkg::TERM_C) begin
					state_d = dtf_pkg::BK_DSTART;
				end else begin
					state_d = dtf_pkg::BK_RSTART;
				end
			end
			dtf_pkg::BK_DSTART: state_d = dtf_pkg::BK_DIV;
			dtf_pkg::BK_DIV: begin
				if (div_done) begin
					state_d = ent_q.onscreen ? dtf_pkg::BK_RD : dtf_pkg::BK_OUT;
				end
			end
			dtf_pkg::BK_RD:     state_d = dtf_pkg::BK_CMP;
			dtf_pkg::BK_CMP:    state_d = dtf_pkg::BK_OUT;
			dtf_pkg::BK_OUT:    if (out_load) state_d = dtf_pkg::BK_IDLE;
			default:            state_d = dtf_pkg::BK_IDLE;
		endcase
	end

	// ---- state outputs
	always_comb begin
		q_pop            = (state_q == dtf_pkg::BK_IDLE) && !q_empty;
		clearing         = state_q == dtf_pkg::BK_CLEAR;
		div_req.start    = (state_q == dtf_pkg::BK_RSTART) || (state_q == dtf_pkg::BK_DSTART);
		div_req.dividend = (state_q == dtf_pkg::BK_DSTART) ? acc_mag : dtf_pkg::RECIP_NUM;
		div_req.divisor  = (state_q == dtf_pkg::BK_DSTART) ? area_mag : cur_w;
		ram_re           = state_q == dtf_pkg::BK_RD;
		ram_we           = clearing || ((state_q == dtf_pkg::BK_CMP) && depth_lt);
		ram_waddr        = clearing ? clr_q : addr;
		ram_wdata        = clearing ? dtf_pkg::ONE_Q16 : depth_q;
		out_load         = (state_q == dtf_pkg::BK_OUT) && (!out_valid_q || pop);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= dtf_pkg::BK_CLEAR;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (clearing) begin
				clr_q <= clr_q + 1'b1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	logic wr_q;

	always_ff @(posedge clk) begin
		case (state_q)
			dtf_pkg::BK_IDLE: begin
				ent_q   <= q_data;
				term_q  <= dtf_pkg::TERM_A;
				chunk_q <= dtf_pkg::CHUNK_LO;
				acc_q   <= '0;
				depth_q <= '0;
				wr_q    <= 1'b0;
			end
			dtf_pkg::BK_RECIP: if (div_done) recip_q <= div_quo[dtf_pkg::RECIP_W-1:0];
			dtf_pkg::BK_MUL:   prod_q <= prod;
			dtf_pkg::BK_ACC: begin
				acc_q <= acc_sum;
				if (chunk_q == dtf_pkg::CHUNK_HI) begin
					chunk_q <= dtf_pkg::CHUNK_LO;
					term_q  <= term_q + 2'd1;
				end else begin
					chunk_q <= chunk_q + 2'd1;
				end
			end
			dtf_pkg::BK_DIV:   if (div_done) depth_q <= depth_sat;
			dtf_pkg::BK_CMP:   wr_q <= depth_lt;
			dtf_pkg::BK_OUT: begin
				if (out_load) begin
					out_write_q <= wr_q;
					out_x_q     <= ent_q.px;
					out_y_q     <= ent_q.py;
					out_color_q <= wr_q ? ent_q.color : 32'd0;
					out_depth_q <= depth_q;
				end
			end
			default: ;
		endcase
	end

	dtf_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.done   (div_done),
		.quo    (div_quo)
	);

	dtf_ram #(
		.WIDTH (32),
		.DEPTH (DEPTH)
	) u_zbuf (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (addr),
		.rdata (ram_rdata)
	);

	assign empty       = !out_valid_q;
	assign write_pixel = out_write_q;
	assign out_x       = out_x_q;
	assign out_y       = out_y_q;
	assign out_color   = out_color_q;
	assign new_depth   = out_depth_q;

endmodule
`default_nettype wire

// ----- hw/rtl/depth_tested_fragment_unit.sv -----
// Two front stages and the two-entry queue lead to the back: three reciprocals, the
//   weighted sum, the final divide and, on screen, a z-buffer read-modify-write; a rejected
//   fragment (zero area or zero w) goes straight to the result. The back takes a new fragment
//   only when done with the last, as the shared bit-serial divider serves all four divides.
// After arst_n the z-buffer is filled with 1.0, one entry a cycle, over all
//   SCREEN_WIDTH*SCREEN_HEIGHT entries (1048576 by default); full stays high till then
`default_nettype none
// ----------------------------------------------------------------------------
// depth_tested_fragment_unit
// Perspective-correct barycentric depth test of one fragment against a z-buffer.
// ----------------------------------------------------------------------------
module depth_tested_fragment_unit #(
	parameter int SCREEN_WIDTH  = dtf_pkg::SCREEN_WIDTH_DEF,
	parameter int SCREEN_HEIGHT = dtf_pkg::SCREEN_HEIGHT_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	// input beats
	input  wire logic               push,
	output logic                    full,
	input  wire logic [9:0]         pixel_x,
	input  wire logic [9:0]         pixel_y,
	input  wire logic signed [12:0] vert_a_x,
	input  wire logic signed [12:0] vert_a_y,
	input  wire logic [31:0]        vert_a_w,
	input  wire logic signed [12:0] vert_b_x,
	input  wire logic signed [12:0] vert_b_y,
	input  wire logic [31:0]        vert_b_w,
	input  wire logic signed [12:0] vert_c_x,
	input  wire logic signed [12:0] vert_c_y,
	input  wire logic [31:0]        vert_c_w,
	input  wire logic [31:0]        fill_color,
	// result beats
	output logic                    empty,
	input  wire logic               pop,
	output logic                    write_pixel,
	output logic [9:0]              out_x,
	output logic [9:0]              out_y,
	output logic [31:0]             out_color,
	output logic signed [31:0]      new_depth
);

	// front to queue
	logic           fq_push;
	dtf_pkg::frag_t fq_data;
	logic           fq_full;
	// queue to back
	logic           qb_pop;
	dtf_pkg::frag_t qb_data;
	logic           qb_empty;
	// back still sweeping the z-buffer after reset
	logic           clearing;

	// front: edge products, areas, classification; holds off while clearing
	dtf_front #(
		.SCREEN_WIDTH  (SCREEN_WIDTH),
		.SCREEN_HEIGHT (SCREEN_HEIGHT)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.hold       (clearing),
		.push       (push),
		.full       (full),
		.pixel_x    (pixel_x),
		.pixel_y    (pixel_y),
		.vert_a_x   (vert_a_x),
		.vert_a_y   (vert_a_y),
		.vert_a_w   (vert_a_w),
		.vert_b_x   (vert_b_x),
		.vert_b_y   (vert_b_y),
		.vert_b_w   (vert_b_w),
		.vert_c_x   (vert_c_x),
		.vert_c_y   (vert_c_y),
		.vert_c_w   (vert_c_w),
		.fill_color (fill_color),
		.q_full     (fq_full),
		.q_push     (fq_push),
		.q_data     (fq_data)
	);

	// short queue so the front keeps taking beats while the back is busy
	dtf_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (fq_push),
		.wdata  (fq_data),
		.full   (fq_full),
		.pop    (qb_pop),
		.rdata  (qb_data),
		.empty  (qb_empty)
	);

	// back: reciprocals, weighted sum, divide, z-buffer read-modify-write,
	// result register that decouples the result side
	dtf_back #(
		.SCREEN_WIDTH  (SCREEN_WIDTH),
		.SCREEN_HEIGHT (SCREEN_HEIGHT)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_empty     (qb_empty),
		.q_pop       (qb_pop),
		.q_data      (qb_data),
		.clearing    (clearing),
		.pop         (pop),
		.empty       (empty),
		.write_pixel (write_pixel),
		.out_x       (out_x),
		.out_y       (out_y),
		.out_color   (out_color),
		.new_depth   (new_depth)
	);

endmodule
`default_nettype wire

// ----- hw/rtl/dtf_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// dtf_checker
// Port-level checks of the depth tested fragment unit.
// ----------------------------------------------------------------------------
module dtf_checker #(
	parameter int SCREEN_WIDTH  = dtf_pkg::SCREEN_WIDTH_DEF,
	parameter int SCREEN_HEIGHT = dtf_pkg::SCREEN_HEIGHT_DEF
) (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               empty,
	input wire logic               pop,
	input wire logic               write_pixel,
	input wire logic [9:0]         out_x,
	input wire logic [9:0]         out_y,
	input wire logic [31:0]        out_color,
	input wire logic signed [31:0] new_depth
);

	// rejected pixels carry no color
	a_color_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !write_pixel) |-> (out_color == 32'd0))
		else $error("color on a rejected pixel");

	// drawn pixels lie on screen
	a_on_screen: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && write_pixel) |-> ((32'(out_x) < 32'(SCREEN_WIDTH))
			&& (32'(out_y) < 32'(SCREEN_HEIGHT))))
		else $error("drawn pixel off screen");

	// stored depths never exceed 1.0, so a pass needs a depth below it
	a_depth_below_one: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && write_pixel) |-> (new_depth < dtf_pkg::ONE_Q16))
		else $error("drawn depth not below 1.0");

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(new_depth) && $stable(out_x)
			&& $stable(write_pixel)))
		else $error("waiting result changed");

endmodule

bind depth_tested_fragment_unit dtf_checker #(
	.SCREEN_WIDTH  (SCREEN_WIDTH),
	.SCREEN_HEIGHT (SCREEN_HEIGHT)
) u_dtf_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.empty       (empty),
	.pop         (pop),
	.write_pixel (write_pixel),
	.out_x       (out_x),
	.out_y       (out_y),
	.out_color   (out_color),
	.new_depth   (new_depth)
);
`default_nettype wire
